// ===== sv/kscd_pkg.sv =====
// ----------------------------------------------------------------------------
// kscd_pkg
// Shared types and constants for the keypad scanner with debounce and chord.
// ----------------------------------------------------------------------------
package kscd_pkg;

  localparam int unsigned SampleW = 12;  // key lines per sample field
  localparam int unsigned CodeW   = 4;   // key code width
  localparam int unsigned InDataW = 24;  // first_sample + confirm_sample
  localparam int unsigned OutDataW = 8;  // key_code padded to a byte

  localparam logic [CodeW-1:0] NoKey     = 4'd0;
  localparam logic [CodeW-1:0] ChordCode = 4'd13;

  // Key 7 and key 8 sit on bits 6 and 7 of a sample.
  localparam int unsigned ChordLo = 6;
  localparam int unsigned ChordHi = 7;

  // One tick's outcome: result word plus next state.
  typedef struct packed {
    logic             emit;
    logic [CodeW-1:0] key_code;
    logic             released;
    logic [CodeW-1:0] last_key_d;
    logic             chord_wait_d;
  } step_t;

endpackage

// ===== sv/kscd_step.sv =====
// ----------------------------------------------------------------------------
// kscd_step
// Per-tick decision: confirm keys, priority encode, chord and release rules.
// ----------------------------------------------------------------------------
module kscd_step #(
  parameter int unsigned KEYS = 12
) (
  input  logic [kscd_pkg::SampleW-1:0] first_sample_i,
  input  logic [kscd_pkg::SampleW-1:0] confirm_sample_i,
  input  logic [kscd_pkg::CodeW-1:0]   last_key_i,
  input  logic                         chord_wait_i,
  output kscd_pkg::step_t              step_o
);

  localparam int unsigned ScanBits =
    (KEYS < kscd_pkg::SampleW) ? KEYS : kscd_pkg::SampleW;

  logic [kscd_pkg::SampleW-1:0] held;
  logic                         found;
  logic [kscd_pkg::CodeW-1:0]   idx;
  logic [kscd_pkg::CodeW-1:0]   code;
  logic                         chord_up;

  // Held only when low in both samples; bits above the scan width ignored.
  always_comb begin
    for (int i = 0; i < int'(kscd_pkg::SampleW); i++) begin
      held[i] = (i < int'(ScanBits)) ? (~first_sample_i[i] & ~confirm_sample_i[i]) : 1'b0;
    end
  end

  // Lowest held key wins.
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = 0; i < int'(kscd_pkg::SampleW); i++) begin
      if (!found && held[i]) begin
        found = 1'b1;
        idx   = kscd_pkg::CodeW'(i);
      end
    end
  end

  assign code     = idx + kscd_pkg::CodeW'(1);
  assign chord_up = confirm_sample_i[kscd_pkg::ChordLo] & confirm_sample_i[kscd_pkg::ChordHi];

  always_comb begin
    step_o.emit         = 1'b0;
    step_o.key_code     = code;
    step_o.released     = 1'b0;
    step_o.last_key_d   = last_key_i;
    step_o.chord_wait_d = chord_wait_i;
    if (chord_wait_i) begin
      // Swallow ticks until both chord keys are up, then report chord once.
      step_o.key_code = kscd_pkg::ChordCode;
      if (chord_up) begin
        step_o.chord_wait_d = 1'b0;
        if (last_key_i != kscd_pkg::ChordCode) begin
          step_o.emit       = 1'b1;
          step_o.last_key_d = kscd_pkg::ChordCode;
        end
      end
    end else if (found) begin
      if (idx == kscd_pkg::CodeW'(kscd_pkg::ChordLo) &&
          !confirm_sample_i[kscd_pkg::ChordHi]) begin
        step_o.chord_wait_d = 1'b1;
      end else if (idx == kscd_pkg::CodeW'(kscd_pkg::ChordHi) &&
                   !confirm_sample_i[kscd_pkg::ChordLo]) begin
        if (last_key_i != kscd_pkg::ChordCode) begin
          step_o.chord_wait_d = 1'b1;
        end
      end else if (last_key_i != code) begin
        step_o.emit       = 1'b1;
        step_o.last_key_d = code;
      end
    end else if (last_key_i != kscd_pkg::NoKey) begin
      // All keys up: release of the last reported key.
      step_o.emit       = 1'b1;
      step_o.key_code   = last_key_i;
      step_o.released   = 1'b1;
      step_o.last_key_d = kscd_pkg::NoKey;
    end
  end

endmodule

// ===== sv/keypad_scan_debounce_chord_top.sv =====
// ----------------------------------------------------------------------------
// keypad_scan_debounce_chord_top
// Debounced priority keypad scanner with a key 7 + key 8 chord.
// ----------------------------------------------------------------------------
// Channel  Dir  Word layout (LSB first)                     Notes
// s_axis   in   tdata[11:0] first_sample, [23:12] confirm   one scan tick/word
// m_axis   out  tdata[3:0] key_code, tuser released         zero or one per tick
//
// Cycles: a tick is registered, decided in the single decision stage between
// the two registers, and its result is registered; one tick is taken every
// cycle unless a held result word stalls the decision stage.
// Reset: rst_ni (async, active low) clears both valids, last_key and
// chord_wait. Stalls: a low m_axis_tready holds the result word; the input
// stage keeps accepting until it holds a tick that cannot move forward.
// Ticks that give no result leave no word; they still wait in the input
// stage while a held result word blocks the decision stage.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_chord_top #(
  parameter int unsigned KEYS = 12  // scanned keys, 8..12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [11:0] first_sample, [23:12] confirm_sample
  input  logic [kscd_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [3:0] key_code, [7:4] zero
  output logic [kscd_pkg::OutDataW-1:0] m_axis_tdata,
  // [0] released
  output logic                          m_axis_tuser
);

  // Input register
  logic                         in_vld_q;
  logic [kscd_pkg::SampleW-1:0] first_q;
  logic [kscd_pkg::SampleW-1:0] conf_q;

  // Scanner state
  logic [kscd_pkg::CodeW-1:0]   last_key_q;
  logic                         chord_wait_q;

  // Result register
  logic                         out_vld_q;
  logic [kscd_pkg::CodeW-1:0]   key_code_q;
  logic                         released_q;

  kscd_pkg::step_t              step;
  logic                         advance;  // result register can take a word
  logic                         fire;     // tick in input register is decided

  assign advance       = !out_vld_q || m_axis_tready;
  assign fire          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  kscd_step #(
    .KEYS(KEYS)
  ) u_step (
    .first_sample_i   (first_q),
    .confirm_sample_i (conf_q),
    .last_key_i       (last_key_q),
    .chord_wait_i     (chord_wait_q),
    .step_o           (step)
  );

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      first_q <= s_axis_tdata[kscd_pkg::SampleW-1:0];
      conf_q  <= s_axis_tdata[2*kscd_pkg::SampleW-1:kscd_pkg::SampleW];
    end
  end

  // State update, once per decided tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_key_q   <= kscd_pkg::NoKey;
      chord_wait_q <= 1'b0;
    end else if (fire) begin
      last_key_q   <= step.last_key_d;
      chord_wait_q <= step.chord_wait_d;
    end
  end

  // Result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= fire && step.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && step.emit) begin
      key_code_q <= step.key_code;
      released_q <= step.released;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(kscd_pkg::OutDataW - kscd_pkg::CodeW){1'b0}}, key_code_q};
  assign m_axis_tuser  = released_q;

  // A release word never carries the empty code.
  a_release_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[kscd_pkg::CodeW-1:0] != kscd_pkg::NoKey)
    else $error("release word with empty key code");

  // The only word leaving a chord wait is the chord press.
  a_chord_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && chord_wait_q && step.emit |=>
      m_axis_tvalid && m_axis_tdata[kscd_pkg::CodeW-1:0] == kscd_pkg::ChordCode &&
      !m_axis_tuser)
    else $error("chord wait left with a non-chord word");

  // A release clears the held key.
  a_release_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && step.emit && step.released |=> last_key_q == kscd_pkg::NoKey)
    else $error("last key not cleared after release");

  // Held key code stays within single keys and the chord.
  a_last_key_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_key_q <= kscd_pkg::ChordCode)
    else $error("last key code out of range");

endmodule

// ===== bench/keypad_scan_debounce_chord_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_scan_debounce_chord_top_test
// Self-checking bench for the debounced keypad scanner with key 7 + 8 chord.
// Scan ticks go in on s_axis. A local scan predictor tracks the held key and
// the chord wait, and queues the press and release events it expects. Each
// m_axis word is checked against the oldest queued event. Ticks cover
// directed corner cases, then random key patterns with bounce noise. The
// sender idles in bursts and the receiver stalls, including one long hold.
// ----------------------------------------------------------------------------
module keypad_scan_debounce_chord_top_test;
  import kscd_pkg::*;

  localparam int unsigned NumKeys     = 12;
  localparam int unsigned RandomTicks = 880;
  localparam int unsigned HoldLen     = 300;     // long receiver hold, cycles
  localparam int unsigned DrainCycles = 8;       // covers the input and result registers
  localparam int unsigned CycleLimit  = 400000;
  localparam logic [SampleW-1:0] ScanMask =
    (NumKeys >= SampleW) ? '1 : SampleW'((1 << NumKeys) - 1);
  localparam logic [SampleW-1:0] AllUp = '1;     // active low: no key down

  // Receiver stall styles
  typedef enum logic [1:0] {RxFree, RxCoin, RxSparse, RxPeriodic} rx_mode_e;

  typedef struct packed {
    logic [CodeW-1:0] key_code;
    logic             released;
  } key_event_t;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // [11:0] first, [23:12] confirm
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // [3:0] key_code, [7:4] zero
  logic                m_axis_tuser;         // [0] released

  // Predictor state, mirrors the block after reset
  logic [CodeW-1:0] held_code   = NoKey;
  logic             chord_armed = 1'b0;

  key_event_t  key_events[$];
  key_event_t  oldest_event;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  // Sender burst control
  int unsigned burst_left = 0;
  logic        gaps_on    = 1'b1;

  // Receiver control; hold requests come from the test, counted down here
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned mode_left     = 0;
  int unsigned rx_phase      = 0;
  rx_mode_e    rx_mode       = RxFree;

  keypad_scan_debounce_chord_top #(
    .KEYS(NumKeys)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // One scan tick: returns 1 and the event when the tick yields a word.
  function automatic logic predict_scan(input logic [SampleW-1:0] first,
                                        input logic [SampleW-1:0] conf,
                                        output key_event_t ev);
    logic [SampleW-1:0] held;
    int unsigned        win;
    held = ~first & ~conf & ScanMask;
    ev   = '0;
    win  = 0;
    // Waiting on the chord: only the confirm lines of keys 7 and 8 matter
    if (chord_armed) begin
      if (!conf[ChordLo] || !conf[ChordHi]) return 1'b0;
      chord_armed = 1'b0;
      if (held_code == ChordCode) return 1'b0;
      held_code   = ChordCode;
      ev.key_code = ChordCode;
      return 1'b1;
    end
    if (held != '0) begin
      for (int i = SampleW - 1; i >= 0; i--) begin
        if (held[i]) win = i;
      end
      if (win == ChordLo && !conf[ChordHi]) begin
        chord_armed = 1'b1;
        return 1'b0;
      end
      if (win == ChordHi && !conf[ChordLo]) begin
        if (held_code != ChordCode) chord_armed = 1'b1;
        return 1'b0;
      end
      if (held_code == win + 1) return 1'b0;
      held_code   = CodeW'(win + 1);
      ev.key_code = held_code;
      return 1'b1;
    end
    if (held_code != NoKey) begin
      ev.key_code = held_code;
      ev.released = 1'b1;
      held_code   = NoKey;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one tick; burst gaps are inserted before the word when due.
  task automatic send_tick(input logic [SampleW-1:0] first,
                           input logic [SampleW-1:0] conf);
    int unsigned gap;
    key_event_t  ev;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {conf, first};
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_scan(first, conf, ev)) key_events.push_back(ev);
  endtask

  // Receiver: long holds on request, otherwise a stall style that changes
  // at random intervals, with free-running stretches among them.
  always @(negedge clk_i) begin
    rx_phase++;
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HoldLen - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 120);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RxFree:     m_axis_tready <= 1'b1;
        RxCoin:     m_axis_tready <= 1'($urandom_range(0, 1));
        RxSparse:   m_axis_tready <= ($urandom_range(0, 3) == 0);
        RxPeriodic: m_axis_tready <= (rx_phase % 7) < 3;
      endcase
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (key_events.size() == 0) begin
        report_mismatch($sformatf("unexpected word code=%0d released=%0b",
                                  m_axis_tdata[CodeW-1:0], m_axis_tuser));
      end else begin
        oldest_event = key_events.pop_front();
        if (m_axis_tdata[CodeW-1:0] !== oldest_event.key_code)
          report_mismatch($sformatf("key_code %0d, wanted %0d",
                                    m_axis_tdata[CodeW-1:0], oldest_event.key_code));
        if (m_axis_tuser !== oldest_event.released)
          report_mismatch($sformatf("released %0b, wanted %0b",
                                    m_axis_tuser, oldest_event.released));
        if (m_axis_tdata[OutDataW-1:CodeW] !== '0)
          report_mismatch($sformatf("pad bits %0h not zero",
                                    m_axis_tdata[OutDataW-1:CodeW]));
      end
    end
  end

  // Idle lines, single keys at both ends, priority, repeats, key change,
  // and samples that disagree (bounce).
  task automatic test_press_release;
    send_tick(AllUp, AllUp);                  // nothing held, nothing known
    send_tick(12'h7FF, 12'h7FF);              // key 12 press
    send_tick(12'h7FF, 12'h7FF);              // still held: silent
    send_tick(12'h000, 12'h000);              // all keys: key 1 wins, change
    send_tick(12'h000, AllUp);                // confirm disagrees: release
    send_tick(AllUp, 12'h000);                // first disagrees, no key known
    send_tick(~12'h040, ~12'h040);            // key 7 alone
    send_tick(~12'h080, ~12'h080);            // key 8 alone, change
  endtask

  // Chord entered through key 7 and key 8, partial release, and the case
  // where the chord was already the last key reported.
  task automatic test_chord;
    send_tick(~12'h0C0, ~12'h0C0);            // via key 7 while key 8 is last
    send_tick(AllUp, ~12'h080);               // key 8 still low: wait
    send_tick(AllUp, AllUp);                  // both up: chord press
    send_tick(~12'h080, ~12'h0C0);            // via key 8, chord last: silent
    send_tick(AllUp, AllUp);                  // chord release
    send_tick(~12'h080, ~12'h0C0);            // via key 8, starts the wait
    send_tick(AllUp, ~12'h040);               // key 7 still low in confirm
    send_tick(AllUp, AllUp);                  // chord press
    send_tick(~12'h0C0, ~12'h0C0);            // via key 7 with chord last
    send_tick(AllUp, AllUp);                  // wait ends, silent
    send_tick(AllUp, AllUp);                  // chord release
    send_tick(~12'h040, ~12'h0C0);            // key 8 low in confirm only
    send_tick(AllUp, AllUp);                  // chord press
    send_tick(AllUp, AllUp);                  // chord release
  endtask

  // Random key patterns held for a few ticks, with bounce on either sample.
  task automatic test_random_scan(input int unsigned count);
    int unsigned        sent;
    int unsigned        reps;
    logic [SampleW-1:0] lines;
    logic [SampleW-1:0] first;
    logic [SampleW-1:0] conf;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2: lines = AllUp;
        3, 4:    lines = ~12'h0C0 & (SampleW'($urandom) | 12'h03F);
        5, 6:    lines = ~(12'h001 << $urandom_range(0, SampleW - 1));
        7, 8:    lines = ~((12'h001 << $urandom_range(0, SampleW - 1)) |
                           (12'h001 << $urandom_range(0, SampleW - 1)));
        default: lines = SampleW'($urandom);
      endcase
      reps = $urandom_range(1, 3);
      repeat (reps) begin
        first = lines;
        conf  = lines;
        if ($urandom_range(0, 5) == 0) first ^= 12'h001 << $urandom_range(0, SampleW - 1);
        if ($urandom_range(0, 7) == 0) conf ^= 12'h001 << $urandom_range(0, SampleW - 1);
        send_tick(first, conf);
        sent++;
      end
    end
  endtask

  // Receiver holds off while every tick yields a word: the block fills
  // and must stall its input without losing or reordering anything.
  task automatic test_backpressure;
    gaps_on = 1'b0;
    hold_requests++;
    for (int i = 0; i < 48; i++) begin
      if (i % 2 == 0) begin
        send_tick(~(12'h001 << (i % SampleW)), ~(12'h001 << (i % SampleW)));
      end else begin
        send_tick(AllUp, AllUp);
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_press_release();
    test_chord();
    test_backpressure();
    test_random_scan(RandomTicks);

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (key_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (key_events.size() != 0)
      report_mismatch($sformatf("%0d key events never arrived", key_events.size()));

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
